>>> sv/kcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types, key codes and helpers of the keypad calculator sequencer.
// ----------------------------------------------------------------------------
package kcs_pkg;

   localparam int KCS_DATA_WIDTH = 32;

   // key codes
   localparam logic [7:0] KEY_ZERO  = 8'h30;
   localparam logic [7:0] KEY_NINE  = 8'h39;
   localparam logic [7:0] KEY_ADD   = 8'h2B;
   localparam logic [7:0] KEY_SUB   = 8'h2D;
   localparam logic [7:0] KEY_MUL   = 8'h2A;
   localparam logic [7:0] KEY_DIV   = 8'h2F;
   localparam logic [7:0] KEY_EQ    = 8'h3D;
   localparam logic [7:0] KEY_CLEAR = 8'h63;

   // column after the answer label
   localparam logic [7:0] COL_ANS = 8'd3;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_MUL   = 3'd3,
      OP_DIV   = 3'd4,
      OP_EQ    = 3'd5,
      OP_OTHER = 3'd6
   } pend_op_type;

   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_SUB = 3'd1,
      ALU_MUL = 3'd2,
      ALU_DIV = 3'd3,
      ALU_DEC = 3'd4
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   function automatic pend_op_type encode_op(input logic [7:0] key);
      pend_op_type op;
      unique case (key)
         KEY_ADD: op = OP_ADD;
         KEY_SUB: op = OP_SUB;
         KEY_MUL: op = OP_MUL;
         KEY_DIV: op = OP_DIV;
         KEY_EQ:  op = OP_EQ;
         default: op = OP_OTHER;
      endcase
      return op;
   endfunction

endpackage
`default_nettype wire

>>> sv/keypad_calculator_sequencer_top.sv
`default_nettype none
// sequencing: keys that apply nothing, and a divide by zero, go straight from
//   idle to done; digit entry, add, subtract, multiply and divide wait in kcs_alu
//   first (multiply and divide one bit per cycle); clear applies its pending operator
// flow: the next request is taken the cycle after the response is
//   registered, so one keypress is handled at a time
// reset: synchronous, clears accumulator, operand, pending operator and column
// ----------------------------------------------------------------------------
// keypad_calculator_sequencer_top
// Four-function immediate-execution calculator driven by keypress codes,
// producing one set of display events per key.
// ----------------------------------------------------------------------------
module keypad_calculator_sequencer_top
   import kcs_pkg::*;
#(
   parameter int DATA_WIDTH = KCS_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_key_code,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_clear_before,
   output logic                       rsp_show_ans_label,
   output logic                       rsp_echo_valid,
   output logic [7:0]                 rsp_echo_char,
   output logic [7:0]                 rsp_echo_column,
   output logic                       rsp_result_valid,
   output logic [DATA_WIDTH-1:0]      rsp_result_value,
   output logic                       rsp_math_error,
   output logic                       rsp_clear_after
);

   localparam int W = DATA_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WAIT = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] opnd_ff, opnd_in;
   pend_op_type pend_ff, pend_in;
   logic [7:0]  col_ff, col_in;
   logic        dst_acc_ff, dst_acc_in;

   logic        p_clr_before_ff, p_clr_before_in;
   logic        p_ans_ff, p_ans_in;
   logic        p_echo_ff, p_echo_in;
   logic [7:0]  p_key_ff, p_key_in;
   logic [7:0]  p_col_ff, p_col_in;
   logic        p_err_ff, p_err_in;
   logic        p_eq_ff, p_eq_in;
   logic        p_clr_ff, p_clr_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;
   logic        rsp_clear_before_ff, rsp_show_ans_label_ff, rsp_echo_valid_ff;
   logic [7:0]  rsp_echo_char_ff, rsp_echo_column_ff;
   logic        rsp_result_valid_ff, rsp_math_error_ff, rsp_clear_after_ff;
   logic [W-1:0] rsp_result_value_ff;

   logic        req_accept;
   logic        is_digit, eq_pend, div0, is_echo;
   logic [3:0]  dsub;
   logic [7:0]  col0;
   logic [W-1:0] acc_base;
   pend_op_type pe;

   alu_cmd_type alu_cmd;
   logic [W-1:0] alu_opa;
   logic        alu_done;
   logic [W-1:0] alu_res;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // decode of the incoming key against the current state
   always_comb begin
      is_digit = (req_key_code >= KEY_ZERO) && (req_key_code <= KEY_NINE);
      dsub     = 4'(req_key_code - KEY_ZERO);
      eq_pend  = (pend_ff == OP_EQ);
      is_echo  = (req_key_code != KEY_EQ);
      if (eq_pend) begin
         col0 = is_digit ? 8'd0 : COL_ANS;
      end else begin
         col0 = col_ff;
      end
      // digit after equals starts a new first number
      acc_base = (eq_pend && is_digit) ? '0 : acc_ff;
      pe       = (eq_pend && is_digit) ? OP_NONE : pend_ff;
      div0     = (pend_ff == OP_DIV) && (opnd_ff == '0);
   end

   always_comb begin
      alu_cmd.start = 1'b0;
      alu_cmd.op    = ALU_DEC;
      alu_opa       = acc_ff;
      if (is_digit) begin
         alu_cmd.start = req_accept;
         alu_cmd.op    = ALU_DEC;
         alu_opa       = (pe == OP_NONE) ? acc_base : opnd_ff;
      end else begin
         unique case (pend_ff)
            OP_ADD: begin
               alu_cmd.start = req_accept;
               alu_cmd.op    = ALU_ADD;
            end
            OP_SUB: begin
               alu_cmd.start = req_accept;
               alu_cmd.op    = ALU_SUB;
            end
            OP_MUL: begin
               alu_cmd.start = req_accept;
               alu_cmd.op    = ALU_MUL;
            end
            OP_DIV: begin
               alu_cmd.start = req_accept && !div0;
               alu_cmd.op    = ALU_DIV;
            end
            default: begin
               alu_cmd.start = 1'b0;
            end
         endcase
      end
   end

   kcs_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_opa),
      .opb    (opnd_ff),
      .digit  (dsub),
      .done   (alu_done),
      .result (alu_res)
   );

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      acc_in          = acc_ff;
      opnd_in         = opnd_ff;
      pend_in         = pend_ff;
      col_in          = col_ff;
      dst_acc_in      = dst_acc_ff;
      p_clr_before_in = p_clr_before_ff;
      p_ans_in        = p_ans_ff;
      p_echo_in       = p_echo_ff;
      p_key_in        = p_key_ff;
      p_col_in        = p_col_ff;
      p_err_in        = p_err_ff;
      p_eq_in         = p_eq_ff;
      p_clr_in        = p_clr_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in          = acc_base;
               pend_in         = is_digit ? pe : encode_op(req_key_code);
               opnd_in         = is_digit ? opnd_ff : '0;
               col_in          = 8'(col0 + 8'd1);
               dst_acc_in      = is_digit ? (pe == OP_NONE) : 1'b1;
               p_clr_before_in = eq_pend;
               p_ans_in        = eq_pend && !is_digit;
               p_echo_in       = is_echo;
               p_key_in        = is_echo ? req_key_code : 8'd0;
               p_col_in        = is_echo ? col0 : 8'd0;
               p_err_in        = !is_digit && div0;
               p_eq_in         = !is_echo;
               p_clr_in        = (req_key_code == KEY_CLEAR);
               state_in        = alu_cmd.start ? ST_WAIT : ST_DONE;
            end
         end
         ST_WAIT: begin
            if (alu_done) begin
               if (dst_acc_ff) begin
                  acc_in = alu_res;
               end else begin
                  opnd_in = alu_res;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               // clear key wipes the state once its echo is out
               if (p_clr_ff) begin
                  acc_in  = '0;
                  opnd_in = '0;
                  pend_in = OP_NONE;
                  col_in  = 8'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         opnd_ff      <= '0;
         pend_ff      <= OP_NONE;
         col_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         opnd_ff      <= opnd_in;
         pend_ff      <= pend_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_acc_ff      <= dst_acc_in;
      p_clr_before_ff <= p_clr_before_in;
      p_ans_ff        <= p_ans_in;
      p_echo_ff       <= p_echo_in;
      p_key_ff        <= p_key_in;
      p_col_ff        <= p_col_in;
      p_err_ff        <= p_err_in;
      p_eq_ff         <= p_eq_in;
      p_clr_ff        <= p_clr_in;
      if (rsp_load) begin
         rsp_clear_before_ff   <= p_clr_before_ff;
         rsp_show_ans_label_ff <= p_ans_ff;
         rsp_echo_valid_ff     <= p_echo_ff;
         rsp_echo_char_ff      <= p_key_ff;
         rsp_echo_column_ff    <= p_col_ff;
         rsp_result_valid_ff   <= p_eq_ff && !p_err_ff;
         rsp_result_value_ff   <= (p_eq_ff && !p_err_ff) ? acc_ff : '0;
         rsp_math_error_ff     <= p_err_ff;
         rsp_clear_after_ff    <= p_clr_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clear_before   = rsp_clear_before_ff;
   assign rsp_show_ans_label = rsp_show_ans_label_ff;
   assign rsp_echo_valid     = rsp_echo_valid_ff;
   assign rsp_echo_char      = rsp_echo_char_ff;
   assign rsp_echo_column    = rsp_echo_column_ff;
   assign rsp_result_valid   = rsp_result_valid_ff;
   assign rsp_result_value   = rsp_result_value_ff;
   assign rsp_math_error     = rsp_math_error_ff;
   assign rsp_clear_after    = rsp_clear_after_ff;

`ifndef SYNTHESIS
   a_result_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid |-> !rsp_math_error)
      else $error("result reported together with math error");

   a_alu_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == ST_WAIT)
      else $error("alu finished outside of wait state");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted request did not start the sequencer");

   a_no_echo_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_echo_valid |-> rsp_echo_char == 8'd0 && rsp_echo_column == 8'd0)
      else $error("echo fields set without echo");
`endif

endmodule
`default_nettype wire

>>> sv/kcs_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kcs_alu
// Iterative arithmetic unit around one shared adder: add, subtract,
// shift-add multiply, restoring divide and decimal digit entry.
// ----------------------------------------------------------------------------
module kcs_alu
   import kcs_pkg::*;
#(
   parameter int DATA_WIDTH = KCS_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire alu_cmd_type           cmd,
   input  wire logic [DATA_WIDTH-1:0] opa,
   input  wire logic [DATA_WIDTH-1:0] opb,
   input  wire logic [3:0]            digit,
   output logic                       done,
   output logic [DATA_WIDTH-1:0]      result
);

   localparam int W     = DATA_WIDTH;
   localparam int CNT_W = $clog2(W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   alu_op_type       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W:0]       acc_ff, acc_in;
   logic [W-1:0]     sh_ff, sh_in;
   logic [W-1:0]     op2_ff, op2_in;

   logic [W:0]       add_x, add_y, sum, rem_sh;
   logic             cin;
   logic [CNT_W-1:0] last_cnt;
   logic             last;

   // one shared adder, operands steered by the running operation
   always_comb begin
      rem_sh = {acc_ff[W-1:0], sh_ff[W-1]};
      add_x  = acc_ff;
      add_y  = {1'b0, op2_ff};
      cin    = 1'b0;
      unique case (op_ff)
         ALU_ADD: begin
            add_y = {1'b0, op2_ff};
         end
         ALU_SUB: begin
            add_y = ~{1'b0, op2_ff};
            cin   = 1'b1;
         end
         ALU_MUL: begin
            add_y = op2_ff[0] ? {1'b0, sh_ff} : '0;
         end
         ALU_DIV: begin
            add_x = rem_sh;
            add_y = ~{1'b0, op2_ff};
            cin   = 1'b1;
         end
         ALU_DEC: begin
            add_y = (cnt_ff == '0) ? {1'b0, sh_ff} : {1'b0, op2_ff};
         end
         default: begin
            add_y = {1'b0, op2_ff};
         end
      endcase
      sum = add_x + add_y + {{W{1'b0}}, cin};
   end

   always_comb begin
      unique case (op_ff)
         ALU_MUL, ALU_DIV: last_cnt = CNT_W'(W - 1);
         ALU_DEC:          last_cnt = CNT_W'(1);
         default:          last_cnt = '0;
      endcase
      last = (cnt_ff == last_cnt);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      op2_in  = op2_ff;
      if (busy_ff) begin
         acc_in = {1'b0, sum[W-1:0]};
         if (op_ff == ALU_MUL) begin
            sh_in  = {sh_ff[W-2:0], 1'b0};
            op2_in = {1'b0, op2_ff[W-1:1]};
         end else if (op_ff == ALU_DIV) begin
            // negative difference: keep the shifted remainder
            acc_in = sum[W] ? rem_sh : sum;
            sh_in  = {sh_ff[W-2:0], ~sum[W]};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = '0;
         unique case (cmd.op)
            ALU_DEC: begin
               // ten times a: 8a now, 2a added on the first step
               acc_in = {1'b0, opa[W-4:0], 3'b000};
               sh_in  = {opa[W-2:0], 1'b0};
               op2_in = {{(W-4){1'b0}}, digit};
            end
            ALU_ADD, ALU_SUB: begin
               acc_in = {1'b0, opa};
               sh_in  = opa;
               op2_in = opb;
            end
            default: begin
               acc_in = '0;
               sh_in  = opa;
               op2_in = opb;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_ADD;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      op2_ff <= op2_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == ALU_DIV) ? sh_ff : acc_ff[W-1:0];

endmodule
`default_nettype wire

>>> verif/keypad_calculator_sequencer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_calculator_sequencer_top_test
// Self-checking testbench for the keypad calculator sequencer. A local model
// of the calculator predicts the display events of every accepted keypress.
// A monitor compares each response against the oldest prediction.
// Stimulus covers directed key sequences, random keypad sessions under
// random idling, a long response hold-off and a column wraparound run.
// ----------------------------------------------------------------------------
module keypad_calculator_sequencer_top_test
   import kcs_pkg::*;
();

   localparam int          CLOCK_HALF   = 2;
   localparam int          RESET_CYCLES = 10;
   localparam int          DRAIN_CYCLES = KCS_DATA_WIDTH + 8;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          LONG_HOLD    = 300;
   localparam int          PHASE_KEYS   = 45;
   localparam int          WRAP_KEYS    = 260;
   localparam int          BURST_KEYS   = 16;
   localparam logic [7:0]  DECIMAL_BASE = 8'd10;

   typedef struct packed {
      logic                      clear_before;
      logic                      show_ans_label;
      logic                      echo_valid;
      logic [7:0]                echo_char;
      logic [7:0]                echo_column;
      logic                      result_valid;
      logic [KCS_DATA_WIDTH-1:0] result_value;
      logic                      math_error;
      logic                      clear_after;
   } display_events_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [7:0]                req_key_code;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_clear_before;
   logic                      rsp_show_ans_label;
   logic                      rsp_echo_valid;
   logic [7:0]                rsp_echo_char;
   logic [7:0]                rsp_echo_column;
   logic                      rsp_result_valid;
   logic [KCS_DATA_WIDTH-1:0] rsp_result_value;
   logic                      rsp_math_error;
   logic                      rsp_clear_after;

   // calculator model state
   logic [KCS_DATA_WIDTH-1:0] calc_acc;
   logic [KCS_DATA_WIDTH-1:0] calc_operand;
   pend_op_type               calc_pending;
   logic [7:0]                calc_column;

   display_events_type expected_events[$];
   int              error_count;
   int              keys_sent;
   int              responses_seen;
   int              div_zero_seen;
   int              cycle_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_cycles;

   keypad_calculator_sequencer_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_clear_before   (rsp_clear_before),
      .rsp_show_ans_label (rsp_show_ans_label),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_char      (rsp_echo_char),
      .rsp_echo_column    (rsp_echo_column),
      .rsp_result_valid   (rsp_result_valid),
      .rsp_result_value   (rsp_result_value),
      .rsp_math_error     (rsp_math_error),
      .rsp_clear_after    (rsp_clear_after)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void clear_calculator();
      calc_acc     = '0;
      calc_operand = '0;
      calc_pending = OP_NONE;
      calc_column  = '0;
   endfunction

   function automatic display_events_type predict_display_events(input logic [7:0] key);
      display_events_type        ev;
      logic                      is_digit;
      logic [KCS_DATA_WIDTH-1:0] digit_value;
      logic                      div_zero;
      ev          = '0;
      div_zero    = 1'b0;
      is_digit    = (key >= KEY_ZERO) && (key <= KEY_NINE);
      digit_value = is_digit ? KCS_DATA_WIDTH'(key - KEY_ZERO) : '0;

      if (calc_pending == OP_EQ) begin
         ev.clear_before = 1'b1;
         if (is_digit) begin
            calc_column  = '0;
            calc_acc     = '0;
            calc_pending = OP_NONE;
         end else begin
            ev.show_ans_label = 1'b1;
            calc_column       = COL_ANS;
         end
      end

      if (!is_digit) begin
         if (calc_pending != OP_NONE) begin
            case (calc_pending)
               OP_ADD: calc_acc = calc_acc + calc_operand;
               OP_SUB: calc_acc = calc_acc - calc_operand;
               OP_MUL: calc_acc = calc_acc * calc_operand;
               OP_DIV: begin
                  if (calc_operand == '0) div_zero = 1'b1;
                  else calc_acc = calc_acc / calc_operand;
               end
               default: ;
            endcase
            calc_operand = '0;
         end
         case (key)
            KEY_ADD: calc_pending = OP_ADD;
            KEY_SUB: calc_pending = OP_SUB;
            KEY_MUL: calc_pending = OP_MUL;
            KEY_DIV: calc_pending = OP_DIV;
            KEY_EQ:  calc_pending = OP_EQ;
            default: calc_pending = OP_OTHER;
         endcase
      end else if (calc_pending == OP_NONE) begin
         calc_acc = calc_acc * DECIMAL_BASE + digit_value;
      end else begin
         calc_operand = calc_operand * DECIMAL_BASE + digit_value;
      end

      ev.result_valid = (key == KEY_EQ) && !div_zero;
      ev.result_value = ev.result_valid ? calc_acc : '0;
      ev.echo_valid   = (key != KEY_EQ);
      if (ev.echo_valid) begin
         ev.echo_char   = key;
         ev.echo_column = calc_column;
      end
      calc_column    = calc_column + 8'd1;
      ev.math_error  = div_zero;
      ev.clear_after = (key == KEY_CLEAR);
      if (ev.clear_after) clear_calculator();
      return ev;
   endfunction

   // receiver side: random stall, or a long counted hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall = (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [KCS_DATA_WIDTH-1:0] exp_value,
                              input logic [KCS_DATA_WIDTH-1:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_value, act_value);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      display_events_type ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (rsp_math_error === 1'b1) div_zero_seen++;
         if (expected_events.size() == 0) begin
            $error("response with no pending request");
            error_count++;
         end else begin
            ev = expected_events.pop_front();
            check_field("clear_before", KCS_DATA_WIDTH'(ev.clear_before),
                        KCS_DATA_WIDTH'(rsp_clear_before));
            check_field("show_ans_label", KCS_DATA_WIDTH'(ev.show_ans_label),
                        KCS_DATA_WIDTH'(rsp_show_ans_label));
            check_field("echo_valid", KCS_DATA_WIDTH'(ev.echo_valid),
                        KCS_DATA_WIDTH'(rsp_echo_valid));
            check_field("echo_char", KCS_DATA_WIDTH'(ev.echo_char),
                        KCS_DATA_WIDTH'(rsp_echo_char));
            check_field("echo_column", KCS_DATA_WIDTH'(ev.echo_column),
                        KCS_DATA_WIDTH'(rsp_echo_column));
            check_field("result_valid", KCS_DATA_WIDTH'(ev.result_valid),
                        KCS_DATA_WIDTH'(rsp_result_valid));
            check_field("result_value", ev.result_value, rsp_result_value);
            check_field("math_error", KCS_DATA_WIDTH'(ev.math_error),
                        KCS_DATA_WIDTH'(rsp_math_error));
            check_field("clear_after", KCS_DATA_WIDTH'(ev.clear_after),
                        KCS_DATA_WIDTH'(rsp_clear_after));
         end
      end
   end

   // called and returns at a falling edge; valid stays high between back-to-back requests
   task automatic send_key(input logic [7:0] key);
      while ((send_idle_pct > 0) && ($urandom_range(0, 99) < send_idle_pct)) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_key_code = key;
      do @(posedge clock); while (req_stall);
      expected_events.push_back(predict_display_events(key));
      keys_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string keys);
      foreach (keys[i]) send_key(keys[i]);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed keypad input, some stray codes
   function automatic logic [7:0] random_key(input bit allow_end);
      logic [7:0] k;
      int         pick;
      do begin
         pick = $urandom_range(0, 99);
         if (pick < 55) k = KEY_ZERO + 8'($urandom_range(0, 9));
         else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0: k = KEY_ADD;
               1: k = KEY_SUB;
               2: k = KEY_MUL;
               default: k = KEY_DIV;
            endcase
         end
         else if (pick < 88) k = KEY_EQ;
         else if (pick < 92) k = KEY_CLEAR;
         else k = 8'($urandom_range(0, 255));
      end while (!allow_end && ((k == KEY_EQ) || (k == KEY_CLEAR)));
      return k;
   endfunction

   task automatic test_arithmetic();
      send_text("7+5=");
      // continue from the answer, subtract wraps below zero
      send_text("-20=");
      send_text("*3=");
      send_text("/0=");
      // digit after equals starts a fresh number
      send_text("8");
      wait_for_drain();
   endtask

   task automatic test_special_keys();
      send_key(8'hFF);
      send_text("3=");
      send_key(8'h00);
      // clear applies the pending divide by zero first
      send_text("9/c9");
      wait_for_drain();
   endtask

   task automatic run_random_phase(input int sender_pct, input int receiver_pct);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (PHASE_KEYS) send_key(random_key(1'b1));
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_cycles = LONG_HOLD;
      @(negedge clock);
      repeat (BURST_KEYS) send_key(random_key(1'b1));
      wait_for_drain();
   endtask

   task automatic test_column_wrap();
      send_key(KEY_CLEAR);
      // no equals or clear, so the column runs past 255
      repeat (WRAP_KEYS) send_key(random_key(1'b0));
      send_key(KEY_EQ);
      wait_for_drain();
   endtask

   initial begin
      req_valid      = 1'b0;
      req_key_code   = '0;
      reset          = 1'b1;
      error_count    = 0;
      keys_sent      = 0;
      responses_seen = 0;
      div_zero_seen  = 0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      hold_cycles    = 0;
      clear_calculator();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_arithmetic();
      test_special_keys();
      run_random_phase(38, 45);
      run_random_phase(45, 38);
      run_random_phase(0, 0);
      test_backpressure();
      test_column_wrap();

      $display("summary: %0d keypresses, %0d responses checked, %0d divide-by-zero events",
               keys_sent, responses_seen, div_zero_seen);
      $display("summary: directed operators, random sessions, long hold-off, column wrap");
      if ((error_count == 0) && (expected_events.size() == 0)) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/kcs_pkg.sv
sv/kcs_alu.sv
sv/keypad_calculator_sequencer_top.sv
verif/keypad_calculator_sequencer_top_test.sv
